// ===== sv/lsse_pkg.sv =====
package lsse_pkg;

	localparam logic signed [31:0] SLOPE_ONE = 32'sh0001_0000;
	localparam logic signed [31:0] S32_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN   = 32'sh8000_0000;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== sv/linear_scaled_squared_error.sv =====
// Least-squares scaled squared error over a vector of Q16.16 sample pairs.
// Input: pulse start with target_sample, predicted_sample and last_sample;
// a word is taken at a clock edge with start high and busy low. While idle
// one pair is taken every cycle; pairs beyond MAX_SAMPLES are dropped.
// The pair marked last ends the vector and raises busy. With scaling on,
// the block then forms both means (one division each), a statistics pass
// over the stored pairs, the slope division and the intercept, and an
// error pass; if the prediction is flat the slope is zero, the intercept
// is the target mean and no slope division runs. With scaling off only
// the error pass runs, with intercept zero and slope one. Each division
// runs in the shared restoring divider at one bit a cycle; a single 33x33
// multiplier serves every product.
// The result is registered on the output ports with done high for exactly one
// cycle; the receiver takes it then and cannot stall. busy is already low then.
// scaling_enable is to be written through scaling_enable_we only while idle;
// the block does not enforce this. Reset clears the pair count, both sums and
// the sequencer, and sets scaling on; the sample stores hold no reset value.
module linear_scaled_squared_error #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] target_sample,
	input  logic signed [31:0] predicted_sample,
	input  logic               last_sample,
	input  logic               scaling_enable_we,
	input  logic               scaling_enable_wdata,
	output logic               done,
	output logic [63:0]        squared_error_sum,
	output logic signed [31:0] fit_intercept,
	output logic signed [31:0] fit_slope,
	output logic               flat_prediction
);

	import lsse_pkg::*;

	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int SW = 32 + CW;
	localparam int XW = 64 + CW;
	localparam int YW = 65 + CW;
	localparam int DW = XW + 16;

	typedef enum logic [4:0] {
		S_IDLE, S_MT_GO, S_MT_W, S_MP_GO, S_MP_W,
		S_P_RD, S_P_M1, S_P_M2, S_P_AC,
		S_SL_CHK, S_SL_W, S_IC_M, S_IC_V,
		S_E_RD, S_E_M, S_E_R, S_E_Q0, S_E_Q1, S_E_Q2, S_E_Q3, S_E_AD,
		S_OUT
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         idx_q;
	logic [CW-1:0]         idx_nx;
	logic signed [SW-1:0]  tsum_q;
	logic signed [SW-1:0]  psum_q;
	logic                  scl_q;
	logic signed [31:0]    mt_q;
	logic signed [31:0]    mp_q;
	logic signed [31:0]    a_q;
	logic signed [31:0]    b_q;
	logic                  neg_q;
	logic                  flat_q;
	logic signed [32:0]    dp_q;
	logic signed [YW-1:0]  sxy_q;
	logic [XW-1:0]         sxx_q;
	logic signed [32:0]    tma_q;
	logic [23:0]           ml_q;
	logic [23:0]           mh_q;
	logic                  big_q;
	logic [95:0]           sq_q;
	logic [63:0]           err_q;
	logic                  done_q;

	logic                  accept;
	logic                  room;
	logic [31:0]           rt_d;
	logic [31:0]           rp_d;
	logic signed [32:0]    dt_c;
	logic signed [32:0]    dp_c;
	logic signed [32:0]    tma_c;
	logic [SW-1:0]         tmag;
	logic [SW-1:0]         pmag;
	logic [YW-1:0]         sxy_mag;
	logic                  div_go;
	logic [DW-1:0]         div_dvd;
	logic [DW-1:0]         div_dvs;
	logic [DW-1:0]         div_quo;
	div_stat_t             dstat;
	logic [31:0]           q32;
	logic [31:0]           q_neg;
	logic                  slope_ovf;
	logic signed [66:0]    v_c;
	logic signed [66:0]    adj_c;
	logic signed [66:0]    sh_c;
	logic                  ic_ovf;
	logic signed [31:0]    a_c;
	logic signed [66:0]    r_c;
	logic [66:0]           m_c;
	logic [64:0]           sum_c;
	logic signed [32:0]    mul_a;
	logic signed [32:0]    mul_b;
	logic signed [65:0]    mul_q;

	assign busy   = state_q != S_IDLE;
	assign accept = start && (state_q == S_IDLE);
	assign room   = cnt_q < CW'(MAX_SAMPLES);
	assign idx_nx = idx_q + 1'b1;

	lsse_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_tgt_ram (
		.clk   (clk),
		.we    (accept && room),
		.waddr (cnt_q[AW-1:0]),
		.wdata (target_sample),
		.raddr (idx_q[AW-1:0]),
		.rdata (rt_d)
	);

	lsse_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_prd_ram (
		.clk   (clk),
		.we    (accept && room),
		.waddr (cnt_q[AW-1:0]),
		.wdata (predicted_sample),
		.raddr (idx_q[AW-1:0]),
		.rdata (rp_d)
	);

	lsse_div #(.W(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_quo),
		.stat     (dstat)
	);

	// centred samples and magnitudes
	assign dt_c    = {rt_d[31], rt_d} - {mt_q[31], mt_q};
	assign dp_c    = {rp_d[31], rp_d} - {mp_q[31], mp_q};
	assign tma_c   = {rt_d[31], rt_d} - {a_q[31], a_q};
	assign tmag    = tsum_q[SW-1] ? SW'(-tsum_q) : SW'(tsum_q);
	assign pmag    = psum_q[SW-1] ? SW'(-psum_q) : SW'(psum_q);
	assign sxy_mag = sxy_q[YW-1] ? YW'(-sxy_q) : YW'(sxy_q);

	always_comb begin
		div_dvd = '0;
		div_dvs = '0;
		div_go  = 1'b0;
		case (state_q)
			S_MT_GO: begin
				div_dvd = DW'(tmag);
				div_dvs = DW'(cnt_q);
				div_go  = 1'b1;
			end
			S_MP_GO: begin
				div_dvd = DW'(pmag);
				div_dvs = DW'(cnt_q);
				div_go  = 1'b1;
			end
			S_SL_CHK: begin
				div_dvd = {sxy_mag[XW-1:0], 16'h0000};
				div_dvs = DW'(sxx_q);
				div_go  = sxx_q != '0;
			end
			default: begin
				div_go = 1'b0;
			end
		endcase
	end

	assign q32       = div_quo[31:0];
	assign q_neg     = 32'(-q32);
	assign slope_ovf = |div_quo[DW-1:31];

	// intercept: (mean_t * 2^16 - b * mean_p) / 2^16, toward zero, saturated
	assign v_c    = 67'($signed({mt_q, 16'h0000})) - 67'(mul_q);
	assign adj_c  = v_c[66] ? v_c + 67'sd65535 : v_c;
	assign sh_c   = adj_c >>> 16;
	assign ic_ovf = !((&sh_c[66:31]) || !(|sh_c[66:31]));
	assign a_c    = ic_ovf ? (sh_c[66] ? S32_MIN : S32_MAX) : sh_c[31:0];

	// residual in units of 2^-32
	assign r_c   = 67'($signed({tma_q, 16'h0000})) - 67'(mul_q);
	assign m_c   = r_c[66] ? 67'(-r_c) : 67'(r_c);
	assign sum_c = {1'b0, err_q} + {1'b0, sq_q[95:32]};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_P_M1: begin
				mul_a = dt_c;
				mul_b = dp_c;
			end
			S_P_M2: begin
				mul_a = dp_q;
				mul_b = dp_q;
			end
			S_IC_M: begin
				mul_a = 33'(b_q);
				mul_b = 33'(mp_q);
			end
			S_E_M: begin
				mul_a = 33'(b_q);
				mul_b = 33'($signed(rp_d));
			end
			S_E_Q0: begin
				mul_a = {9'h000, ml_q};
				mul_b = {9'h000, ml_q};
			end
			S_E_Q1: begin
				mul_a = {9'h000, mh_q};
				mul_b = {9'h000, ml_q};
			end
			S_E_Q2: begin
				mul_a = {9'h000, mh_q};
				mul_b = {9'h000, mh_q};
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			cnt_q             <= '0;
			idx_q             <= '0;
			tsum_q            <= '0;
			psum_q            <= '0;
			scl_q             <= 1'b1;
			mt_q              <= '0;
			mp_q              <= '0;
			a_q               <= '0;
			b_q               <= '0;
			neg_q             <= 1'b0;
			flat_q            <= 1'b0;
			dp_q              <= '0;
			sxy_q             <= '0;
			sxx_q             <= '0;
			tma_q             <= '0;
			ml_q              <= '0;
			mh_q              <= '0;
			big_q             <= 1'b0;
			sq_q              <= '0;
			err_q             <= '0;
			done_q            <= 1'b0;
			squared_error_sum <= '0;
			fit_intercept     <= '0;
			fit_slope         <= '0;
			flat_prediction   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (scaling_enable_we) begin
				scl_q <= scaling_enable_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (room) begin
							cnt_q  <= cnt_q + 1'b1;
							tsum_q <= tsum_q + SW'(target_sample);
							psum_q <= psum_q + SW'(predicted_sample);
						end
						if (last_sample) begin
							if (scl_q) begin
								state_q <= S_MT_GO;
							end else begin
								a_q     <= '0;
								b_q     <= SLOPE_ONE;
								flat_q  <= 1'b0;
								idx_q   <= '0;
								err_q   <= '0;
								state_q <= S_E_RD;
							end
						end
					end
				end
				S_MT_GO: state_q <= S_MT_W;
				S_MT_W: begin
					if (dstat.done) begin
						mt_q    <= tsum_q[SW-1] ? q_neg : q32;
						state_q <= S_MP_GO;
					end
				end
				S_MP_GO: state_q <= S_MP_W;
				S_MP_W: begin
					if (dstat.done) begin
						mp_q    <= psum_q[SW-1] ? q_neg : q32;
						sxy_q   <= '0;
						sxx_q   <= '0;
						idx_q   <= '0;
						state_q <= S_P_RD;
					end
				end
				S_P_RD: state_q <= S_P_M1;
				S_P_M1: begin
					dp_q    <= dp_c;
					state_q <= S_P_M2;
				end
				S_P_M2: begin
					sxy_q   <= sxy_q + YW'(mul_q);
					state_q <= S_P_AC;
				end
				S_P_AC: begin
					sxx_q <= sxx_q + XW'(mul_q[63:0]);
					idx_q <= idx_nx;
					state_q <= (idx_nx == cnt_q) ? S_SL_CHK : S_P_RD;
				end
				S_SL_CHK: begin
					neg_q <= sxy_q[YW-1];
					if (sxx_q == '0) begin
						// flat prediction: slope forced to zero
						flat_q  <= 1'b1;
						b_q     <= '0;
						a_q     <= mt_q;
						idx_q   <= '0;
						err_q   <= '0;
						state_q <= S_E_RD;
					end else begin
						flat_q  <= 1'b0;
						state_q <= S_SL_W;
					end
				end
				S_SL_W: begin
					if (dstat.done) begin
						if (slope_ovf) begin
							b_q <= neg_q ? S32_MIN : S32_MAX;
						end else begin
							b_q <= neg_q ? q_neg : q32;
						end
						state_q <= S_IC_M;
					end
				end
				S_IC_M: state_q <= S_IC_V;
				S_IC_V: begin
					a_q     <= a_c;
					idx_q   <= '0;
					err_q   <= '0;
					state_q <= S_E_RD;
				end
				S_E_RD: state_q <= S_E_M;
				S_E_M: begin
					tma_q   <= tma_c;
					state_q <= S_E_R;
				end
				S_E_R: begin
					ml_q    <= m_c[23:0];
					mh_q    <= m_c[47:24];
					big_q   <= |m_c[66:48];
					state_q <= S_E_Q0;
				end
				S_E_Q0: state_q <= S_E_Q1;
				S_E_Q1: begin
					sq_q    <= 96'(mul_q[47:0]);
					state_q <= S_E_Q2;
				end
				S_E_Q2: begin
					// cross term counted twice
					sq_q    <= sq_q + (96'(mul_q[47:0]) << 25);
					state_q <= S_E_Q3;
				end
				S_E_Q3: begin
					sq_q    <= sq_q + (96'(mul_q[47:0]) << 48);
					state_q <= S_E_AD;
				end
				S_E_AD: begin
					err_q <= (big_q || sum_c[64]) ? '1 : sum_c[63:0];
					idx_q <= idx_nx;
					state_q <= (idx_nx == cnt_q) ? S_OUT : S_E_RD;
				end
				S_OUT: begin
					squared_error_sum <= err_q;
					fit_intercept     <= a_q;
					fit_slope         <= b_q;
					flat_prediction   <= flat_q;
					done_q            <= 1'b1;
					cnt_q             <= '0;
					tsum_q            <= '0;
					psum_q            <= '0;
					state_q           <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;

endmodule

// ===== sv/lsse_ram.sv =====
module lsse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/lsse_div.sv =====
module lsse_div #(
	parameter int W = 91
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [W-1:0]           dividend,
	input  logic [W-1:0]           divisor,
	output logic [W-1:0]           quotient,
	output lsse_pkg::div_stat_t    stat
);

	import lsse_pkg::*;

	localparam int NW = $clog2(W);
	localparam logic [NW-1:0] LAST_STEP = NW'(W - 1);

	logic [W-1:0]  qd_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic [NW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          ge;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, qd_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qd_q   <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				qd_q  <= dividend;
				dvs_q <= divisor;
				rem_q <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
				qd_q  <= {qd_q[W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient  = qd_q;
	assign stat.busy = run_q;
	assign stat.done = done_q;

endmodule

// ===== verif/tb_linear_scaled_squared_error.sv =====
module tb_linear_scaled_squared_error;
	import lsse_pkg::*;

	localparam int DEPTH = 1024;

	typedef struct {
		logic [63:0]        err_sum;
		logic signed [31:0] intercept;
		logic signed [31:0] slope;
		logic               flat;
	} fit_result_t;

	class fit_scoreboard;
		logic signed [31:0] tgt_mem [DEPTH];
		logic signed [31:0] pred_mem [DEPTH];
		int                 n_held;
		logic signed [63:0] tgt_acc;
		logic signed [63:0] pred_acc;
		logic               scale_on;
		fit_result_t        expected_fits [$];
		int                 errors;

		function new();
			n_held = 0;
			tgt_acc = 0;
			pred_acc = 0;
			scale_on = 1'b1;
			errors = 0;
		endfunction

		function void set_scaling(logic v);
			scale_on = v;
		endfunction

		function void note_word(logic signed [31:0] t, logic signed [31:0] p, logic l);
			if (n_held < DEPTH) begin
				tgt_mem[n_held] = t;
				pred_mem[n_held] = p;
				tgt_acc += t;
				pred_acc += p;
				n_held++;
			end
			if (l) begin
				expected_fits = {expected_fits, fit_vector()};
				n_held = 0;
				tgt_acc = 0;
				pred_acc = 0;
			end
		endfunction

		function fit_result_t fit_vector();
			fit_result_t        res;
			logic signed [63:0] cnt, mt, mp;
			logic signed [127:0] ti, pi, dt, dp, sxy, sxx, num, quo, aa, bb, resid, tmp;
			logic [127:0]       sq;
			logic [64:0]        acc;
			logic               neg;
			cnt = n_held;
			mt = tgt_acc / cnt;
			mp = pred_acc / cnt;
			res.flat = 1'b0;
			if (scale_on) begin
				sxy = 0;
				sxx = 0;
				for (int i = 0; i < n_held; i++) begin
					ti = tgt_mem[i];
					pi = pred_mem[i];
					dt = ti - mt;
					dp = pi - mp;
					sxy += dt * dp;
					sxx += dp * dp;
				end
				if (sxx == 0) begin
					res.flat = 1'b1;
					bb = 0;
					aa = mt;
				end else begin
					neg = sxy < 0;
					num = (neg ? -sxy : sxy) <<< 16;
					quo = num / sxx;
					if (quo >= (128'sd1 <<< 31))
						bb = neg ? S32_MIN : S32_MAX;
					else
						bb = neg ? -quo : quo;
					tmp = mt;
					tmp = (tmp * 65536 - bb * mp) / 65536;
					if (tmp > S32_MAX) aa = S32_MAX;
					else if (tmp < S32_MIN) aa = S32_MIN;
					else aa = tmp;
				end
			end else begin
				aa = 0;
				bb = SLOPE_ONE;
			end
			acc = 0;
			for (int i = 0; i < n_held; i++) begin
				ti = tgt_mem[i];
				pi = pred_mem[i];
				resid = ti * 65536 - aa * 65536 - bb * pi;
				if (resid < 0) resid = -resid;
				sq = resid * resid;
				if (sq[127:96] != 0) acc = {1'b0, {64{1'b1}}};
				else begin
					acc = acc + sq[95:32];
					if (acc[64]) acc = {1'b0, {64{1'b1}}};
				end
			end
			res.err_sum = acc[63:0];
			res.intercept = aa[31:0];
			res.slope = bb[31:0];
			return res;
		endfunction

		function bit pending();
			return expected_fits.size() != 0;
		endfunction

		function void check_fit(fit_result_t got);
			fit_result_t want;
			if (expected_fits.size() == 0) begin
				$display("%0t: unexpected result err=%h a=%h b=%h flat=%b", $time,
					got.err_sum, got.intercept, got.slope, got.flat);
				errors++;
				return;
			end
			want = expected_fits.pop_front();
			if (got.err_sum !== want.err_sum) begin
				$display("%0t: squared_error_sum expected %h actual %h", $time,
					want.err_sum, got.err_sum);
				errors++;
			end
			if (got.intercept !== want.intercept) begin
				$display("%0t: fit_intercept expected %h actual %h", $time,
					want.intercept, got.intercept);
				errors++;
			end
			if (got.slope !== want.slope) begin
				$display("%0t: fit_slope expected %h actual %h", $time,
					want.slope, got.slope);
				errors++;
			end
			if (got.flat !== want.flat) begin
				$display("%0t: flat_prediction expected %b actual %b", $time,
					want.flat, got.flat);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] target_sample;
	logic signed [31:0] predicted_sample;
	logic               last_sample;
	logic               scaling_enable_we;
	logic               scaling_enable_wdata;
	logic               done;
	logic [63:0]        squared_error_sum;
	logic signed [31:0] fit_intercept;
	logic signed [31:0] fit_slope;
	logic               flat_prediction;

	fit_scoreboard fit_sb = new();
	int            idle_pct;

	linear_scaled_squared_error DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.target_sample(target_sample),
		.predicted_sample(predicted_sample),
		.last_sample(last_sample),
		.scaling_enable_we(scaling_enable_we),
		.scaling_enable_wdata(scaling_enable_wdata),
		.done(done),
		.squared_error_sum(squared_error_sum),
		.fit_intercept(fit_intercept),
		.fit_slope(fit_slope),
		.flat_prediction(flat_prediction)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		fit_result_t got;
		if (arst_n && done) begin
			got.err_sum = squared_error_sum;
			got.intercept = fit_intercept;
			got.slope = fit_slope;
			got.flat = flat_prediction;
			fit_sb.check_fit(got);
		end
	end

	task automatic send_word(input logic signed [31:0] t, input logic signed [31:0] p,
			input logic l);
		start <= 1'b1;
		target_sample <= t;
		predicted_sample <= p;
		last_sample <= l;
		@(posedge clk);
		while (busy) @(posedge clk);
		fit_sb.note_word(t, p, l);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// hold the sender until every result is in and the block is idle again
	task automatic wait_idle();
		start <= 1'b0;
		while (fit_sb.pending()) @(posedge clk);
		@(posedge clk);
		while (busy) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_scaling(input logic v);
		wait_idle();
		scaling_enable_we <= 1'b1;
		scaling_enable_wdata <= v;
		@(posedge clk);
		fit_sb.set_scaling(v);
		scaling_enable_we <= 1'b0;
		scaling_enable_wdata <= $urandom_range(1);
	endtask

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(9))
			0: return S32_MIN;
			1: return S32_MAX;
			2: return 0;
			3, 4, 5: return $signed($urandom_range(0, 2097151)) - 1048576;
			default: return $urandom;
		endcase
	endfunction

	// vector shapes: full random, near-linear, flat prediction
	task automatic send_vector(input int len);
		int                 shape;
		logic signed [31:0] t, p, p_flat, gain, offs;
		shape = $urandom_range(5);
		p_flat = pick_word();
		gain = $signed($urandom_range(0, 262143)) - 131072;
		offs = $signed($urandom_range(0, 1048575)) - 524288;
		for (int i = 0; i < len; i++) begin
			case (shape)
				0, 1: begin
					t = pick_word();
					p = pick_word();
				end
				2, 3: begin
					p = $signed($urandom_range(0, 65535)) - 32768;
					t = offs + ((gain * p) >>> 16) + $signed($urandom_range(0, 63)) - 32;
				end
				4: begin
					t = pick_word();
					p = p_flat;
				end
				default: begin
					t = $urandom;
					p = $urandom;
				end
			endcase
			send_word(t, p, i == len - 1);
		end
	endtask

	initial begin
		int ph_items;
		int len;
		arst_n = 1'b0;
		start = 1'b0;
		target_sample = 0;
		predicted_sample = 0;
		last_sample = 1'b0;
		scaling_enable_we = 1'b0;
		scaling_enable_wdata = 1'b0;
		idle_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: scaling on from reset
		send_word(32'sh0001_0000, 32'sh0002_0000, 1'b1);
		send_word(S32_MAX, S32_MIN, 1'b0);
		send_word(S32_MIN, S32_MAX, 1'b1);
		send_word(32'sh0003_0000, 32'sh0001_0000, 1'b0);
		send_word(32'sh0005_0000, 32'sh0002_0000, 1'b0);
		send_word(32'sh0007_0000, 32'sh0003_0000, 1'b1);
		send_word(32'sh1234_5678, 32'sh0000_4000, 1'b0);
		send_word(-32'sh1234_5678, 32'sh0000_4000, 1'b1);
		// slope saturates both ways
		send_word(S32_MAX, 32'sh0000_0000, 1'b0);
		send_word(S32_MIN, 32'sh0000_0001, 1'b1);
		send_word(S32_MIN, 32'sh0000_0000, 1'b0);
		send_word(S32_MAX, 32'sh0000_0001, 1'b1);
		write_scaling(1'b0);
		send_word(S32_MAX, S32_MIN, 1'b1);
		send_word(S32_MIN, S32_MAX, 1'b0);
		send_word(S32_MAX, S32_MIN, 1'b0);
		send_word(S32_MIN, S32_MAX, 1'b1);
		send_word(32'sh0001_8000, 32'sh0001_0000, 1'b1);
		write_scaling(1'b1);

		// a vector longer than the store: surplus words are dropped
		for (int i = 0; i < DEPTH + 6; i++)
			send_word($urandom, $urandom, i == DEPTH + 5);

		for (int ph = 0; ph < 4; ph++) begin
			write_scaling(ph[0]);
			case (ph)
				0: idle_pct = 0;
				1: idle_pct = 57;
				2: idle_pct = 18;
				default: idle_pct = 57;
			endcase
			ph_items = 0;
			while (ph_items < 205) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				send_vector(len);
				ph_items += len;
				if ($urandom_range(19) == 0) wait_idle();
			end
		end
		wait_idle();
		repeat (20) @(posedge clk);
		if (fit_sb.errors == 0 && !fit_sb.pending())
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
